[hw/rtl/gpm_pkg.sv]
// Shared types and byte codes for the glob pattern matcher.
`timescale 1ns / 1ps
package gpm_pkg;

   typedef enum logic [1:0] {
      OP_PAT_APPEND  = 2'd0,
      OP_PAT_CLEAR   = 2'd1,
      OP_SUBJ_APPEND = 2'd2,
      OP_MATCH       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_RUN,
      T_HOLD
   } top_state_type;

   typedef enum logic [3:0] {
      E_IDLE,
      E_TOP,
      E_ELEM,
      E_STAR,
      E_STAR_RD,
      E_ESC,
      E_BR_NEG,
      E_BR_M,
      E_BR_M_D,
      E_BR_D1,
      E_BR_D2,
      E_TAIL,
      E_TAIL_RD,
      E_DONE
   } eng_state_type;

   typedef struct packed {
      logic start;
      logic escape_disable;
   } eng_cmd_type;

   typedef struct packed {
      logic done;
      logic matched;
   } eng_sts_type;

   localparam logic [0:0] REG_ESCAPE_DISABLE = 1'd0;

   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

endpackage

[hw/rtl/gpm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module gpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/gpm_engine.sv]
// Match sequencer: walks pattern and subject memories, one read per cycle.
`timescale 1ns / 1ps
module gpm_engine #(
   parameter int PATTERN_DEPTH = 64,
   parameter int SUBJECT_DEPTH = 256,
   parameter int LW  = $clog2(PATTERN_DEPTH + 2),
   parameter int SLW = $clog2(SUBJECT_DEPTH + 1),
   parameter int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1,
   parameter int SAW = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gpm_pkg::eng_cmd_type cmd,
   input  logic [LW-1:0]        plen,
   input  logic [SLW-1:0]       slen,
   input  logic [7:0]           pat_rdata,
   input  logic [7:0]           subj_rdata,
   output logic [PAW-1:0]       pat_raddr,
   output logic [SAW-1:0]       subj_raddr,
   output gpm_pkg::eng_sts_type sts
);
   import gpm_pkg::*;

   eng_state_type st_ff, st_in;
   logic [LW-1:0]  pp_ff, pp_in, rpp_ff, rpp_in, q_ff, q_in;
   logic [SLW-1:0] sp_ff, sp_in, rsp_ff, rsp_in;
   logic rv_ff, rv_in, neg_ff, neg_in, hit_ff, hit_in, first_ff, first_in;
   logic res_ff, res_in;
   logic [7:0] c_ff, c_in, m_ff, m_in;

   logic [LW:0] pp1, pp2, q1, q2, q3, plen_x;
   logic [SLW:0] rsp1;
   logic [LW:0] paddr_w;
   logic succ, fail;
   logic [LW-1:0] pnext;

   assign pp1    = {1'b0, pp_ff} + 1'b1;
   assign pp2    = {1'b0, pp_ff} + 2'd2;
   assign q1     = {1'b0, q_ff} + 1'b1;
   assign q2     = {1'b0, q_ff} + 2'd2;
   assign q3     = {1'b0, q_ff} + 2'd3;
   assign plen_x = {1'b0, plen};
   assign rsp1   = {1'b0, rsp_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= E_IDLE;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
      end
      pp_ff    <= pp_in;
      rpp_ff   <= rpp_in;
      q_ff     <= q_in;
      sp_ff    <= sp_in;
      rsp_ff   <= rsp_in;
      neg_ff   <= neg_in;
      hit_ff   <= hit_in;
      first_ff <= first_in;
      res_ff   <= res_in;
      c_ff     <= c_in;
      m_ff     <= m_in;
   end

   always_comb begin
      st_in    = st_ff;
      pp_in    = pp_ff;
      rpp_in   = rpp_ff;
      q_in     = q_ff;
      sp_in    = sp_ff;
      rsp_in   = rsp_ff;
      rv_in    = rv_ff;
      neg_in   = neg_ff;
      hit_in   = hit_ff;
      first_in = first_ff;
      res_in   = res_ff;
      c_in     = c_ff;
      m_in     = m_ff;
      paddr_w  = {1'b0, pp_ff};
      succ     = 1'b0;
      fail     = 1'b0;
      pnext    = pp1[LW-1:0];

      unique case (st_ff)
         E_IDLE: begin
            if (cmd.start) begin
               pp_in  = '0;
               sp_in  = '0;
               rpp_in = '0;
               rsp_in = '0;
               rv_in  = 1'b0;
               st_in  = E_TOP;
            end
         end
         E_TOP: begin
            if (sp_ff >= slen) begin
               st_in = E_TAIL;
            end else if (pp_ff < plen) begin
               st_in = E_ELEM;
            end else begin
               fail = 1'b1;
            end
         end
         E_ELEM: begin
            c_in = subj_rdata;
            if (pat_rdata == CH_STAR) begin
               pp_in = pp1[LW-1:0];
               st_in = E_STAR;
            end else if (pat_rdata == CH_QUEST) begin
               succ = 1'b1;
            end else if (pat_rdata == CH_LBRACK && pp1 < plen_x) begin
               paddr_w  = pp1;
               neg_in   = 1'b0;
               hit_in   = 1'b0;
               first_in = 1'b1;
               st_in    = E_BR_NEG;
            end else if (pat_rdata == CH_BSLASH && !cmd.escape_disable
                         && pp1 < plen_x) begin
               paddr_w = pp1;
               st_in   = E_ESC;
            end else if (subj_rdata == pat_rdata) begin
               succ = 1'b1;
            end else begin
               fail = 1'b1;
            end
         end
         E_STAR: begin
            if (pp_ff == plen) begin
               res_in = 1'b1;
               st_in  = E_DONE;
            end else begin
               st_in = E_STAR_RD;
            end
         end
         E_STAR_RD: begin
            if (pat_rdata == CH_STAR) begin
               pp_in = pp1[LW-1:0];
               st_in = E_STAR;
            end else begin
               rpp_in = pp_ff;
               rsp_in = sp_ff;
               rv_in  = 1'b1;
               st_in  = E_TOP;
            end
         end
         E_ESC: begin
            pnext = pp2[LW-1:0];
            if (c_ff == pat_rdata) begin
               succ = 1'b1;
            end else begin
               fail = 1'b1;
            end
         end
         E_BR_NEG: begin
            if (pat_rdata == CH_BANG || pat_rdata == CH_CARET) begin
               neg_in = 1'b1;
               q_in   = pp2[LW-1:0];
            end else begin
               q_in = pp1[LW-1:0];
            end
            st_in = E_BR_M;
         end
         E_BR_M: begin
            if (q_ff < plen) begin
               paddr_w = {1'b0, q_ff};
               st_in   = E_BR_M_D;
            end else if (c_ff == CH_LBRACK) begin
               succ = 1'b1;
            end else begin
               fail = 1'b1;
            end
         end
         E_BR_M_D: begin
            m_in = pat_rdata;
            if (pat_rdata == CH_RBRACK && !first_ff) begin
               pnext = q1[LW-1:0];
               if (hit_ff != neg_ff) begin
                  succ = 1'b1;
               end else begin
                  fail = 1'b1;
               end
            end else if (q2 < plen_x) begin
               paddr_w = q1;
               st_in   = E_BR_D1;
            end else begin
               if (c_ff == pat_rdata) begin
                  hit_in = 1'b1;
               end
               q_in     = q1[LW-1:0];
               first_in = 1'b0;
               st_in    = E_BR_M;
            end
         end
         E_BR_D1: begin
            if (pat_rdata == CH_DASH) begin
               paddr_w = q2;
               st_in   = E_BR_D2;
            end else begin
               if (c_ff == m_ff) begin
                  hit_in = 1'b1;
               end
               q_in     = q1[LW-1:0];
               first_in = 1'b0;
               st_in    = E_BR_M;
            end
         end
         E_BR_D2: begin
            if (pat_rdata != CH_RBRACK) begin
               if (c_ff >= m_ff && c_ff <= pat_rdata) begin
                  hit_in = 1'b1;
               end
               q_in = q3[LW-1:0];
            end else begin
               if (c_ff == m_ff) begin
                  hit_in = 1'b1;
               end
               q_in = q1[LW-1:0];
            end
            first_in = 1'b0;
            st_in    = E_BR_M;
         end
         E_TAIL: begin
            if (pp_ff < plen) begin
               st_in = E_TAIL_RD;
            end else begin
               res_in = (pp_ff == plen);
               st_in  = E_DONE;
            end
         end
         E_TAIL_RD: begin
            if (pat_rdata == CH_STAR) begin
               pp_in = pp1[LW-1:0];
               st_in = E_TAIL;
            end else begin
               res_in = 1'b0;
               st_in  = E_DONE;
            end
         end
         E_DONE: begin
            st_in = E_IDLE;
         end
         default: begin
            st_in = E_IDLE;
         end
      endcase

      if (succ) begin
         pp_in = pnext;
         sp_in = sp_ff + 1'b1;
         st_in = E_TOP;
      end else if (fail) begin
         if (rv_ff) begin
            rsp_in = rsp1[SLW-1:0];
            sp_in  = rsp1[SLW-1:0];
            pp_in  = rpp_ff;
            st_in  = E_TOP;
         end else begin
            res_in = 1'b0;
            st_in  = E_DONE;
         end
      end
   end

   assign pat_raddr   = paddr_w[PAW-1:0];
   assign subj_raddr  = sp_ff[SAW-1:0];
   assign sts.done    = (st_ff == E_DONE);
   assign sts.matched = res_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> st_ff == E_IDLE)
      else $error("match start while busy");
   a_pp_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff != E_IDLE |-> pp_ff <= plen)
      else $error("pattern position beyond length");
   a_retry_bound: assert property (@(posedge clock) disable iff (reset)
      rv_ff && st_ff == E_TOP |-> rsp_ff <= sp_ff)
      else $error("retry position ahead of subject position");
`endif

endmodule

[hw/rtl/glob_pattern_matcher_unit.sv]
// Top level of the glob pattern matcher: item loading, result register, CSR.
// Load and clear items are taken one item per cycle while no match is in progress.
// A match item walks the pattern element by element, trying class members one at a time and
// retrying after a star; each step reads the pattern memory, so classes and retries set the time.
// An overflowed match skips the engine and goes straight to the hold state; the result waits in an output register.
// Reset: synchronous, active high; clears lengths, flags, CSR and control state.
// Memory contents are not cleared; only entries below the lengths are ever used.
`timescale 1ns / 1ps
module glob_pattern_matcher_unit #(
   parameter int PATTERN_DEPTH = 64,
   parameter int SUBJECT_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_matched,
   output logic        rsp_overflow,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import gpm_pkg::*;

   localparam int LW  = $clog2(PATTERN_DEPTH + 2);
   localparam int SLW = $clog2(SUBJECT_DEPTH + 1);
   localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int SAW = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1;
   localparam logic [LW-1:0]  PMAX = LW'(PATTERN_DEPTH);
   localparam logic [SLW-1:0] SMAX = SLW'(SUBJECT_DEPTH);

   top_state_type st_ff, st_in;
   logic [LW-1:0]  plen_ff, plen_in;   // depth+1 marks pattern overflow
   logic [SLW-1:0] slen_ff, slen_in;
   logic ovf_seen_ff, ovf_seen_in;
   logic esc_ff, esc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_matched_ff, rsp_matched_in, rsp_ovf_ff, rsp_ovf_in;
   logic res_m_ff, res_m_in, res_o_ff, res_o_in;   // finished result, waiting for slot

   logic pat_we, subj_we;
   logic [PAW-1:0] pat_raddr;
   logic [SAW-1:0] subj_raddr;
   logic [7:0] pat_rdata, subj_rdata;
   eng_cmd_type cmd;
   eng_sts_type sts;
   op_type op;
   logic acc, csr_wr;

   assign op     = op_type'(req_operation);
   assign acc    = req_valid && req_ready;
   assign csr_wr = psel && penable && pwrite && pready;

   gpm_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
      .clock (clock),
      .we    (pat_we),
      .waddr (plen_ff[PAW-1:0]),
      .wdata (req_byte_value),
      .raddr (pat_raddr),
      .rdata (pat_rdata)
   );

   gpm_ram #(.WIDTH(8), .DEPTH(SUBJECT_DEPTH)) u_subj_ram (
      .clock (clock),
      .we    (subj_we),
      .waddr (slen_ff[SAW-1:0]),
      .wdata (req_byte_value),
      .raddr (subj_raddr),
      .rdata (subj_rdata)
   );

   gpm_engine #(.PATTERN_DEPTH(PATTERN_DEPTH), .SUBJECT_DEPTH(SUBJECT_DEPTH)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .plen       (plen_ff),
      .slen       (slen_ff),
      .pat_rdata  (pat_rdata),
      .subj_rdata (subj_rdata),
      .pat_raddr  (pat_raddr),
      .subj_raddr (subj_raddr),
      .sts        (sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= T_IDLE;
         plen_ff      <= '0;
         slen_ff      <= '0;
         ovf_seen_ff  <= 1'b0;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         plen_ff      <= plen_in;
         slen_ff      <= slen_in;
         ovf_seen_ff  <= ovf_seen_in;
         esc_ff       <= esc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_matched_ff <= rsp_matched_in;
      rsp_ovf_ff     <= rsp_ovf_in;
      res_m_ff       <= res_m_in;
      res_o_ff       <= res_o_in;
   end

   always_comb begin
      st_in          = st_ff;
      plen_in        = plen_ff;
      slen_in        = slen_ff;
      ovf_seen_in    = ovf_seen_ff;
      esc_in         = esc_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_matched_in = rsp_matched_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      res_m_in       = res_m_ff;
      res_o_in       = res_o_ff;
      pat_we         = 1'b0;
      subj_we        = 1'b0;
      cmd.start      = 1'b0;
      cmd.escape_disable = esc_ff;

      // escape mode must be written only while idle (a user rule; the block itself does not enforce it)
      if (csr_wr && paddr[2] == REG_ESCAPE_DISABLE) begin
         esc_in = pwdata[0];
      end

      unique case (st_ff)
         T_IDLE: begin
            if (acc) begin
               unique case (op)
                  OP_PAT_APPEND: begin
                     if (plen_ff < PMAX) begin
                        pat_we  = 1'b1;
                        plen_in = plen_ff + 1'b1;
                     end else begin
                        plen_in = PMAX + 1'b1;
                     end
                  end
                  OP_PAT_CLEAR: begin
                     plen_in = '0;
                  end
                  OP_SUBJ_APPEND: begin
                     if (slen_ff < SMAX) begin
                        subj_we = 1'b1;
                        slen_in = slen_ff + 1'b1;
                     end else begin
                        ovf_seen_in = 1'b1;
                     end
                  end
                  OP_MATCH: begin
                     if (ovf_seen_ff || plen_ff > PMAX) begin
                        res_m_in = 1'b0;
                        res_o_in = 1'b1;
                        st_in    = T_HOLD;
                     end else begin
                        cmd.start = 1'b1;
                        res_o_in  = 1'b0;
                        st_in     = T_RUN;
                     end
                  end
                  default: begin
                     st_in = T_IDLE;
                  end
               endcase
            end
         end
         T_RUN: begin
            if (sts.done) begin
               res_m_in = sts.matched;
               st_in    = T_HOLD;
            end
         end
         T_HOLD: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = res_m_ff;
               rsp_ovf_in     = res_o_ff;
               slen_in        = '0;
               ovf_seen_in    = 1'b0;
               st_in          = T_IDLE;
            end
         end
         default: begin
            st_in = T_IDLE;
         end
      endcase
   end

   assign req_ready    = (st_ff == T_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_matched  = rsp_matched_ff;
   assign rsp_overflow = rsp_ovf_ff;
   assign pready       = 1'b1;
   assign prdata       = (paddr[2] == REG_ESCAPE_DISABLE) ? {31'd0, esc_ff} : 32'd0;

`ifndef ASSERT_OFF
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> st_ff == T_RUN)
      else $error("engine finished outside a match");
   a_ovf_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_matched)
      else $error("overflow result reports a match");
   a_plen_bound: assert property (@(posedge clock) disable iff (reset)
      plen_ff <= PMAX + 1'b1 && slen_ff <= SMAX)
      else $error("length beyond store");
   a_slen_clear: assert property (@(posedge clock) disable iff (reset)
      st_ff == T_HOLD && st_in == T_IDLE |=> slen_ff == '0 && !ovf_seen_ff)
      else $error("subject not cleared after match");
`endif

endmodule
